// ===== design/assert_macros.svh =====
// Assertion macros used by the slot table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKST_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lkst_pkg.sv =====
// Types, codes and helper functions of the label keyed object slot table.
`timescale 1ns / 1ps
package lkst_pkg;

    localparam int LABEL_W = 64;
    localparam int LEN_W   = 4;
    localparam int REF_W   = 32;
    localparam int SIZE_W  = 32;

    // DER header constants
    localparam logic [7:0]        DER_SEQ_TAG  = 8'h30;
    localparam logic [7:0]        DER_INT_TAG  = 8'h02;
    localparam logic [7:0]        DER_BASE_IDX = 8'd2;
    localparam logic [SIZE_W-1:0] DER_MIN_SIZE = 32'd4;

    typedef enum logic [1:0] {
        OP_SAVE    = 2'd0,
        OP_FIND    = 2'd1,
        OP_GET     = 2'd2,
        OP_DESTROY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADARG   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    // One slot entry as kept in the slot RAM
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [LEN_W-1:0]   len;
        logic [REF_W-1:0]   pref;
        logic [SIZE_W-1:0]  size;
        logic               priv;
    } t_slot;

    // Zero the label bytes at and past the length
    function automatic logic [LABEL_W-1:0] label_mask(input logic [LABEL_W-1:0] bytes,
                                                      input logic [LEN_W-1:0]   len);
        logic [LABEL_W-1:0] m;
        m = '0;
        for (int b = 0; b < LABEL_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                m[b*8 +: 8] = bytes[b*8 +: 8];
            end
        end
        return m;
    endfunction

    // Private key flag from the DER header: SEQUENCE whose first element is INTEGER
    function automatic logic der_private(input logic [SIZE_W-1:0] size,
                                         input logic [7:0]        first,
                                         input logic [7:0]        lenoct,
                                         input logic [7:0]        inner);
        logic [7:0] idx;
        idx = lenoct[7] ? (DER_BASE_IDX + {1'b0, lenoct[6:0]}) : DER_BASE_IDX;
        if (size < DER_MIN_SIZE || first != DER_SEQ_TAG) begin
            return 1'b0;
        end
        if ({24'd0, idx} >= size) begin
            return 1'b0;
        end
        return (inner == DER_INT_TAG);
    endfunction

endpackage

// ===== design/lkst_slot_ram.sv =====
// Single write port, single read port slot RAM with registered read data.
`timescale 1ns / 1ps
module lkst_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  lkst_pkg::t_slot     i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output lkst_pkg::t_slot     o_rdata
);
    import lkst_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/label_keyed_object_slot_table.sv =====
// Top level of the label keyed object slot table.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall   | operation, label, handle, payload
//  out     | output    | o_out_valid / i_out_stall | status, handle, payload, flag
//
//  One item is in work at a time. Save and find walk the slot RAM one entry
//  per cycle and stop at the first label match or after the last entry.
//  Get does one RAM read; destroy and rejected items go straight to done.
//  The result sits in an output register; the next beat is taken while it waits.
//  Reset is synchronous and clears all used bits at once; no clearing pass.
//
`include "assert_macros.svh"

module label_keyed_object_slot_table #(
    parameter int NUM_SLOTS       = 16,
    parameter int LABEL_MAX_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_operation,
    input  logic [lkst_pkg::LABEL_W-1:0]     i_label_bytes,
    input  logic [lkst_pkg::LEN_W-1:0]       i_label_length,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   i_handle_in,
    input  logic [lkst_pkg::REF_W-1:0]       i_payload_ref,
    input  logic [lkst_pkg::SIZE_W-1:0]      i_payload_size,
    input  logic [7:0]                       i_der_first,
    input  logic [7:0]                       i_der_length_octet,
    input  logic [7:0]                       i_der_inner_tag,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_status,
    output logic [$clog2(NUM_SLOTS+1)-1:0]   o_handle_out,
    output logic [lkst_pkg::REF_W-1:0]       o_payload_ref_out,
    output logic [lkst_pkg::SIZE_W-1:0]      o_payload_size_out,
    output logic                             o_is_private
);
    import lkst_pkg::*;

    localparam int H_W   = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LABEL_MAX_BYTES);

    t_state r_state, n_state;

    // captured request
    t_op                r_op;
    logic [LABEL_W-1:0] r_label;
    logic [LEN_W-1:0]   r_len;
    logic [REF_W-1:0]   r_pref;
    logic [SIZE_W-1:0]  r_psize;
    logic               r_priv;

    // scan control
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic               r_issue, n_issue;
    logic               r_rd_valid, n_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;

    // used bits
    logic [NUM_SLOTS-1:0] r_used, n_used;

    // staged result
    t_status            r_res_status, n_res_status;
    logic [H_W-1:0]     r_res_handle, n_res_handle;
    logic [REF_W-1:0]   r_res_ref, n_res_ref;
    logic [SIZE_W-1:0]  r_res_size, n_res_size;
    logic               r_res_priv, n_res_priv;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [H_W-1:0]     r_out_handle;
    logic [REF_W-1:0]   r_out_ref;
    logic [SIZE_W-1:0]  r_out_size;
    logic               r_out_priv;

    // RAM ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_slot              ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    t_slot              ram_rdata;

    logic               in_accept;
    logic               out_free;
    t_op                in_op;
    logic               label_good;
    logic [H_W-1:0]     handle_m1;
    logic [IDX_W-1:0]   handle_idx;
    logic               handle_good;
    logic               scan_hit;
    logic               scan_cur_free;
    logic               scan_end;
    logic               free_any;
    logic [IDX_W-1:0]   free_pick;

    lkst_slot_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request checks
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_op       = t_op'(i_operation);
    assign label_good  = (i_label_length != '0) && (i_label_length <= LEN_MAX);
    assign handle_m1   = i_handle_in - H_W'(1);
    assign handle_idx  = handle_m1[IDX_W-1:0];
    assign handle_good = (i_handle_in != '0) && (i_handle_in <= H_W'(NUM_SLOTS))
                         && r_used[handle_idx];

    // compare stage of the scan, one entry per cycle
    assign scan_hit      = r_rd_valid && r_used[r_rd_idx] && (ram_rdata.len == r_len)
                           && (ram_rdata.label == r_label);
    assign scan_cur_free = r_rd_valid && !r_used[r_rd_idx];
    assign scan_end      = scan_hit || (r_rd_valid && (r_rd_idx == LAST_IDX));
    assign free_any      = r_free_found || scan_cur_free;
    assign free_pick     = r_free_found ? r_free_idx : r_rd_idx;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (in_op)
                        OP_SAVE:    n_state = (label_good && i_payload_size != '0)
                                              ? S_SCAN : S_DONE;
                        OP_FIND:    n_state = label_good ? S_SCAN : S_DONE;
                        OP_GET:     n_state = handle_good ? S_READ : S_DONE;
                        OP_DESTROY: n_state = S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN:  n_state = scan_end ? S_DONE : S_SCAN;
            S_READ:  n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls and result staging
    always_comb begin
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_rd_valid   = 1'b0;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_ref    = r_res_ref;
        n_res_size   = r_res_size;
        n_res_priv   = r_res_priv;
        ram_we       = 1'b0;
        ram_waddr    = r_rd_idx;
        ram_wdata    = '{label: r_label, len: r_len, pref: r_pref,
                         size: r_psize, priv: r_priv};
        ram_raddr    = r_addr;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = handle_idx;
                if (in_accept) begin
                    n_res_status = ST_OK;
                    n_res_handle = '0;
                    n_res_ref    = '0;
                    n_res_size   = '0;
                    n_res_priv   = 1'b0;
                    n_addr       = '0;
                    n_issue      = 1'b1;
                    n_free_found = 1'b0;
                    unique case (in_op)
                        OP_SAVE: begin
                            if (!label_good || i_payload_size == '0) begin
                                n_res_status = ST_BADARG;
                            end
                        end
                        OP_FIND: begin
                            if (!label_good) begin
                                n_res_status = ST_BADARG;
                            end
                        end
                        OP_GET: begin
                            if (!handle_good) begin
                                n_res_status = ST_NOTFOUND;
                            end
                        end
                        OP_DESTROY: begin
                            if (!handle_good) begin
                                n_res_status = ST_NOTFOUND;
                            end else begin
                                n_used[handle_idx] = 1'b0;
                            end
                        end
                        default: n_res_status = ST_NOTFOUND;
                    endcase
                end
            end
            S_SCAN: begin
                // issue stage
                if (r_issue) begin
                    n_rd_valid = 1'b1;
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                // remember the lowest free slot seen so far
                if (scan_cur_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
                // finish on first match or after the last entry
                if (scan_end) begin
                    n_rd_valid = 1'b0;
                    n_issue    = 1'b0;
                    if (r_op == OP_FIND) begin
                        if (scan_hit) begin
                            n_res_handle = H_W'(r_rd_idx) + H_W'(1);
                        end else begin
                            n_res_status = ST_NOTFOUND;
                        end
                    end else if (scan_hit || free_any) begin
                        ram_we            = 1'b1;
                        ram_waddr         = scan_hit ? r_rd_idx : free_pick;
                        n_used[ram_waddr] = 1'b1;
                        n_res_handle      = H_W'(ram_waddr) + H_W'(1);
                    end else begin
                        n_res_status = ST_FULL;
                    end
                end
            end
            S_READ: begin
                n_res_ref  = ram_rdata.pref;
                n_res_size = ram_rdata.size;
                n_res_priv = ram_rdata.priv;
            end
            S_DONE: begin
                n_rd_valid = 1'b0;
            end
            default: n_rd_valid = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_issue      <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_issue      <= n_issue;
            r_rd_valid   <= n_rd_valid;
            r_free_found <= n_free_found;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_rd_idx     <= r_addr;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_ref    <= n_res_ref;
        r_res_size   <= n_res_size;
        r_res_priv   <= n_res_priv;
        if (in_accept) begin
            r_op    <= in_op;
            r_label <= label_mask(i_label_bytes, i_label_length);
            r_len   <= i_label_length;
            r_pref  <= i_payload_ref;
            r_psize <= i_payload_size;
            r_priv  <= der_private(i_payload_size, i_der_first, i_der_length_octet,
                                   i_der_inner_tag);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_ref    <= r_res_ref;
            r_out_size   <= r_res_size;
            r_out_priv   <= r_res_priv;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_handle_out       = r_out_handle;
    assign o_payload_ref_out  = r_out_ref;
    assign o_payload_size_out = r_out_size;
    assign o_is_private       = r_out_priv;

    // checks
    `LKST_ASSERT_IMP(a_out_from_done, $rose(o_out_valid), $past(r_state) == S_DONE, "result beat not from done state")
    `LKST_ASSERT_IMP(a_handle_ok, o_out_valid && (o_handle_out != '0), o_status == ST_OK, "handle returned with failing status")
    `LKST_ASSERT_IMP(a_priv_get_only, o_out_valid && o_is_private, (o_status == ST_OK) && (o_handle_out == '0), "private flag outside a good get")
    `LKST_ASSERT_NEXT(a_busy_after_accept, in_accept, o_in_stall, "request side open while item in work")

endmodule
